// ===== rtl/planar_arm_forward_kinematics_top_macros.svh =====
// Assertion macros for the planar arm forward kinematics checker.
// Depends on nothing; included by the checker file only.
`ifndef PLANAR_ARM_FORWARD_KINEMATICS_TOP_MACROS_SVH
`define PLANAR_ARM_FORWARD_KINEMATICS_TOP_MACROS_SVH

// Antecedent holds, so the consequent holds in the same cycle.
`define PAFK_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Antecedent holds, so the consequent holds in the next cycle.
`define PAFK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/pafk_pkg.sv =====
// Shared types and constants of the planar arm forward kinematics block.
// Depends on nothing; used by the CORDIC cell and the top level.
package pafk_pkg;
	localparam logic [1:0] REG_LINK_COUNT = 2'd0;
	localparam logic [1:0] REG_LENGTH_FIRST = 2'd1;
	localparam logic [1:0] REG_LENGTH_SECOND = 2'd2;
	localparam logic [1:0] REG_LENGTH_THIRD = 2'd3;

	localparam int LANES = 3;
	localparam int POS_W = 19;
	localparam int POS_LIMIT = 196605;
	localparam logic [33:0] GAIN_Q30 = 34'h026DD3B6A;

	localparam logic [31:0] ATAN_TURN32 [24] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

	typedef struct packed {
		logic vld;
		logic [1:0] sel;
		logic [LANES-1:0] flip;
	} pafk_ctl_t;
endpackage

// ===== rtl/pafk_cell.sv =====
// One CORDIC rotation step for the three joint lanes, with its own register.
// Depends on pafk_pkg for the control struct and the arctangent table.
module pafk_cell #(
	parameter int XW = 34,
	parameter int ZW = 18,
	parameter int AB = 16,
	parameter int STAGE = 0
) (
	input logic clk,
	input logic arst_n,
	input pafk_pkg::pafk_ctl_t ctl_in,
	input logic signed [XW-1:0] x_in [3],
	input logic signed [XW-1:0] y_in [3],
	input logic signed [ZW-1:0] z_in [3],
	input logic rdy_next,
	output logic rdy,
	output pafk_pkg::pafk_ctl_t ctl_out,
	output logic signed [XW-1:0] x_out [3],
	output logic signed [XW-1:0] y_out [3],
	output logic signed [ZW-1:0] z_out [3]
);
	import pafk_pkg::*;

	localparam int E = 32 - AB;
	localparam logic [32:0] ASUM = {1'b0, ATAN_TURN32[STAGE]} + (33'd1 << (E - 1));
	localparam logic signed [ZW-1:0] A = ZW'(ASUM >> E);

	pafk_ctl_t ctl_q;
	logic signed [XW-1:0] x_q [3];
	logic signed [XW-1:0] y_q [3];
	logic signed [ZW-1:0] z_q [3];

	assign rdy = !ctl_q.vld || rdy_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else if (rdy) begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy) begin
			for (int k = 0; k < LANES; k++) begin
				if (!z_in[k][ZW-1]) begin
					x_q[k] <= x_in[k] - (y_in[k] >>> STAGE);
					y_q[k] <= y_in[k] + (x_in[k] >>> STAGE);
					z_q[k] <= z_in[k] - A;
				end else begin
					x_q[k] <= x_in[k] + (y_in[k] >>> STAGE);
					y_q[k] <= y_in[k] - (x_in[k] >>> STAGE);
					z_q[k] <= z_in[k] + A;
				end
			end
		end
	end

	assign ctl_out = ctl_q;
	assign x_out = x_q;
	assign y_out = y_q;
	assign z_out = z_q;
endmodule

// ===== rtl/planar_arm_forward_kinematics_top.sv =====
// Top level of the planar arm forward kinematics block: configuration,
// angle preparation, the chain of CORDIC cells, link scaling and output.
// Depends on pafk_pkg and pafk_cell.
// The block takes one joint query per cycle while in_stall is low. The angles
// are summed and folded into the first register, then pass through the chain
// of CORDIC cells, a register for the length multiplies and an output register
// that adds, saturates and holds the result. Each stage holds while the stage
// after it is full and stalled, so bubbles close up; the output register takes
// a new item only when it is empty or its finished result is being taken.
module planar_arm_forward_kinematics_top #(
	parameter int ANGLE_BITS = 16,
	parameter int CORDIC_STAGES = 16
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [1:0] cfg_index,
	input logic [15:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic signed [15:0] angle_first,
	input logic signed [15:0] angle_second,
	input logic signed [15:0] angle_third,
	input logic [1:0] joint_select,
	output logic out_valid,
	input logic out_stall,
	output logic signed [pafk_pkg::POS_W-1:0] pos_x,
	output logic signed [pafk_pkg::POS_W-1:0] pos_y,
	output logic index_valid
);
	import pafk_pkg::*;

	localparam int AB = ANGLE_BITS;
	localparam int XW = 34;
	localparam int ZW = AB + 2;
	localparam int PW = XW + 17;
	localparam int SW = PW + 2;
	localparam int SHL = (AB > 16) ? AB - 16 : 0;
	localparam int SHR = (AB < 16) ? 16 - AB : 0;
	localparam int N = CORDIC_STAGES;

	logic [1:0] link_count_q;
	logic [15:0] len_q [3];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_count_q <= 2'd2;
			len_q[0] <= 16'd256;
			len_q[1] <= 16'd256;
			len_q[2] <= 16'd256;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LINK_COUNT: link_count_q <= cfg_data[1:0];
				REG_LENGTH_FIRST: len_q[0] <= cfg_data;
				REG_LENGTH_SECOND: len_q[1] <= cfg_data;
				REG_LENGTH_THIRD: len_q[2] <= cfg_data;
				default: link_count_q <= link_count_q;
			endcase
		end
	end

	pafk_ctl_t ctl_c [N+1];
	logic signed [XW-1:0] x_c [N+1][3];
	logic signed [XW-1:0] y_c [N+1][3];
	logic signed [ZW-1:0] z_c [N+1][3];
	logic rdy_c [N+2];

	logic [15:0] cum [3];
	logic [AB+15:0] wide [3];
	logic [AB-1:0] p [3];
	logic [2:0] flip;

	assign cum[0] = angle_first;
	assign cum[1] = angle_first + angle_second;
	assign cum[2] = angle_first + angle_second + angle_third;

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			wide[k] = ({{AB{1'b0}}, cum[k]} << SHL) >> SHR;
			p[k] = wide[k][AB-1:0];
			flip[k] = p[k][AB-1] ^ p[k][AB-2];
			if (flip[k]) begin
				p[k][AB-1] = ~p[k][AB-1];
			end
		end
	end

	pafk_ctl_t ctl_s1;
	logic signed [ZW-1:0] z_s1 [3];

	assign in_stall = !rdy_c[0];
	assign rdy_c[0] = !ctl_s1.vld || rdy_c[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (rdy_c[0]) begin
			ctl_s1.vld <= in_valid;
			ctl_s1.sel <= joint_select;
			ctl_s1.flip <= flip;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_c[0]) begin
			for (int k = 0; k < LANES; k++) begin
				z_s1[k] <= ZW'($signed(p[k]));
			end
		end
	end

	assign ctl_c[0] = ctl_s1;
	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			x_c[0][k] = $signed(GAIN_Q30);
			y_c[0][k] = '0;
			z_c[0][k] = z_s1[k];
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		pafk_cell #(.XW(XW), .ZW(ZW), .AB(AB), .STAGE(i)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl_in(ctl_c[i]),
			.x_in(x_c[i]),
			.y_in(y_c[i]),
			.z_in(z_c[i]),
			.rdy_next(rdy_c[i+2]),
			.rdy(rdy_c[i+1]),
			.ctl_out(ctl_c[i+1]),
			.x_out(x_c[i+1]),
			.y_out(y_c[i+1]),
			.z_out(z_c[i+1])
		);
	end

	pafk_ctl_t ctl_s2;
	logic signed [PW-1:0] px_s2 [3];
	logic signed [PW-1:0] py_s2 [3];
	logic rdy_s2;
	logic rdy_out;
	logic signed [XW-1:0] tx [3];
	logic signed [XW-1:0] ty [3];

	// The chain's last cell sees the multiply stage as its successor.
	assign rdy_c[N+1] = rdy_s2;
	assign rdy_s2 = !ctl_s2.vld || rdy_out;

	always_comb begin
		for (int k = 0; k < LANES; k++) begin
			tx[k] = ctl_c[N].flip[k] ? -x_c[N][k] : x_c[N][k];
			ty[k] = ctl_c[N].flip[k] ? -y_c[N][k] : y_c[N][k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (rdy_s2) begin
			ctl_s2 <= ctl_c[N];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			for (int k = 0; k < LANES; k++) begin
				px_s2[k] <= tx[k] * $signed({1'b0, len_q[k]});
				py_s2[k] <= ty[k] * $signed({1'b0, len_q[k]});
			end
		end
	end

	logic signed [PW-1:0] rx;
	logic signed [PW-1:0] ry;
	logic signed [SW-1:0] sx;
	logic signed [SW-1:0] sy;
	logic [1:0] links;
	logic iv;
	logic signed [POS_W-1:0] qx;
	logic signed [POS_W-1:0] qy;
	logic out_valid_q;
	logic signed [POS_W-1:0] pos_x_q;
	logic signed [POS_W-1:0] pos_y_q;
	logic index_valid_q;

	assign rdy_out = !out_valid_q || !out_stall;
	assign links = (link_count_q == 2'd2) ? 2'd2 : 2'd3;
	assign iv = ctl_s2.sel <= links;

	always_comb begin
		sx = '0;
		sy = '0;
		for (int k = 0; k < LANES; k++) begin
			rx = (px_s2[k] + $signed(PW'(64'd1 << 29))) >>> 30;
			ry = (py_s2[k] + $signed(PW'(64'd1 << 29))) >>> 30;
			if (k < int'(ctl_s2.sel)) begin
				sx = sx + SW'(rx);
				sy = sy + SW'(ry);
			end
		end
		if (sx > SW'(POS_LIMIT)) begin
			qx = POS_W'(POS_LIMIT);
		end else if (sx < -SW'(POS_LIMIT)) begin
			qx = -POS_W'(POS_LIMIT);
		end else begin
			qx = sx[POS_W-1:0];
		end
		if (sy > SW'(POS_LIMIT)) begin
			qy = POS_W'(POS_LIMIT);
		end else if (sy < -SW'(POS_LIMIT)) begin
			qy = -POS_W'(POS_LIMIT);
		end else begin
			qy = sy[POS_W-1:0];
		end
		if (!iv) begin
			qx = '0;
			qy = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy_out) begin
			out_valid_q <= ctl_s2.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out) begin
			pos_x_q <= qx;
			pos_y_q <= qy;
			index_valid_q <= iv;
		end
	end

	assign out_valid = out_valid_q;
	assign pos_x = pos_x_q;
	assign pos_y = pos_y_q;
	assign index_valid = index_valid_q;
endmodule

// ===== rtl/pafk_checker.sv =====
// Port-level checker for the planar arm forward kinematics top level.
// Depends on pafk_pkg and the assertion macro header; bound to the top level.
`include "planar_arm_forward_kinematics_top_macros.svh"

module pafk_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_stall,
	input logic signed [pafk_pkg::POS_W-1:0] pos_x,
	input logic signed [pafk_pkg::POS_W-1:0] pos_y,
	input logic index_valid
);
	import pafk_pkg::*;

	`PAFK_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`PAFK_ASSERT_NOW(a_bad_index_zero, clk, arst_n, out_valid && !index_valid, pos_x == 0 && pos_y == 0)
	`PAFK_ASSERT_NOW(a_x_range, clk, arst_n, out_valid, pos_x <= POS_LIMIT && pos_x >= -POS_LIMIT)
	`PAFK_ASSERT_NOW(a_y_range, clk, arst_n, out_valid, pos_y <= POS_LIMIT && pos_y >= -POS_LIMIT)
endmodule

bind planar_arm_forward_kinematics_top pafk_checker u_pafk_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.pos_x(pos_x),
	.pos_y(pos_y),
	.index_valid(index_valid)
);

// ===== tb/tb_top.sv =====
// Testbench for the planar arm forward kinematics block: drives joint queries
// and register writes, predicts each position with its own CORDIC, and compares.
// Depends on pafk_pkg and planar_arm_forward_kinematics_top.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import pafk_pkg::*;

	localparam int LIMIT_CYCLES = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [15:0] angle_first = '0;
	logic signed [15:0] angle_second = '0;
	logic signed [15:0] angle_third = '0;
	logic [1:0] joint_select = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic index_valid;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic ok;
	} joint_pos_t;

	joint_pos_t pending_pos[$];
	int errors = 0;
	int cycles = 0;
	logic [1:0] arm_links = 2'd2;
	logic [15:0] arm_len[3] = '{16'd256, 16'd256, 16'd256};
	int stall_mode = 0;

	planar_arm_forward_kinematics_top DUT (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	function automatic logic signed [63:0] shr_floor(logic signed [63:0] v, int s);
		return v >>> s;
	endfunction

	task automatic sin_cos(input logic [15:0] ang, output logic signed [63:0] c,
			output logic signed [63:0] s);
		logic [15:0] p;
		logic signed [63:0] x, y, z, a, dx, dy;
		logic flip;
		p = ang;
		x = 64'sh26DD3B6A;
		y = 0;
		flip = 1'b0;
		if (p >= 16'h4000 && p < 16'hC000) begin
			flip = 1'b1;
			p = p - 16'h8000;
		end
		z = (p >= 16'h8000) ? 64'(p) - 65536 : 64'(p);
		for (int i = 0; i < 16; i++) begin
			a = 64'((64'(ATAN_TURN32[i]) + 64'h8000) >> 16);
			dx = shr_floor(y, i);
			dy = shr_floor(x, i);
			if (z >= 0) begin
				x = x - dx; y = y + dy; z = z - a;
			end else begin
				x = x + dx; y = y - dy; z = z + a;
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	function automatic logic signed [POS_W-1:0] clamp_pos(logic signed [63:0] v);
		if (v > POS_LIMIT) v = POS_LIMIT;
		if (v < -POS_LIMIT) v = -POS_LIMIT;
		return v[POS_W-1:0];
	endfunction

	task automatic predict_joint(input logic [15:0] a0, a1, a2, input logic [1:0] sel);
		joint_pos_t r;
		logic [15:0] ang[3];
		logic [15:0] cum;
		logic signed [63:0] px, py, c, s;
		int links;
		links = (arm_links == 2'd2) ? 2 : 3;
		ang = '{a0, a1, a2};
		cum = 0; px = 0; py = 0;
		if (sel > links) begin
			r = '{x: '0, y: '0, ok: 1'b0};
		end else begin
			for (int k = 0; k < sel; k++) begin
				cum = cum + ang[k];
				sin_cos(cum, c, s);
				px += shr_floor(64'(arm_len[k]) * c + (64'sd1 << 29), 30);
				py += shr_floor(64'(arm_len[k]) * s + (64'sd1 << 29), 30);
			end
			r = '{x: clamp_pos(px), y: clamp_pos(py), ok: 1'b1};
		end
		pending_pos.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("tb_top: mismatch %s got %0d expected %0d", what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		joint_pos_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pos.size() == 0) begin
				report_mismatch("unexpected item", 0, 0);
			end else begin
				e = pending_pos.pop_front();
				if (pos_x !== e.x) report_mismatch("pos_x", pos_x, e.x);
				if (pos_y !== e.y) report_mismatch("pos_y", pos_y, e.y);
				if (index_valid !== e.ok) report_mismatch("index_valid", index_valid, e.ok);
			end
		end
	end

	always @(posedge clk) begin
		case (stall_mode)
		0: out_stall <= 1'b0;
		1: out_stall <= ($urandom_range(0, 3) == 0);
		default: out_stall <= ($urandom_range(0, 1) == 0);
		endcase
	end

	task automatic send_query(input logic [15:0] a0, a1, a2, input logic [1:0] sel);
		in_valid <= 1'b1;
		angle_first <= a0;
		angle_second <= a1;
		angle_third <= a2;
		joint_select <= sel;
		do @(posedge clk); while (in_stall);
		predict_joint(a0, a1, a2, sel);
	endtask

	task automatic idle_input(input int n);
		in_valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		int waited;
		idle_input(1);
		while (pending_pos.size() != 0) @(posedge clk);
		waited = 0;
		while (waited < 24) begin
			@(posedge clk);
			waited++;
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
		REG_LINK_COUNT: arm_links = val[1:0];
		REG_LENGTH_FIRST: arm_len[0] = val;
		REG_LENGTH_SECOND: arm_len[1] = val;
		default: arm_len[2] = val;
		endcase
	endtask

	task automatic set_arm(input logic [1:0] lc, input logic [15:0] l0, l1, l2);
		drain();
		write_reg(REG_LINK_COUNT, 16'(lc));
		write_reg(REG_LENGTH_FIRST, l0);
		write_reg(REG_LENGTH_SECOND, l1);
		write_reg(REG_LENGTH_THIRD, l2);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_burst(input int n);
		int left;
		left = n;
		while (left > 0) begin
			int burst;
			burst = $urandom_range(1, 20);
			for (int i = 0; i < burst && left > 0; i++, left--) begin
				case ($urandom_range(0, 3))
				0: send_query(16'($urandom_range(0, 15) << 12),
						16'($urandom_range(0, 15) << 12),
						16'($urandom_range(0, 15) << 12), 2'($urandom_range(0, 3)));
				default: send_query(16'($urandom), 16'($urandom), 16'($urandom),
						2'($urandom_range(0, 3)));
				endcase
			end
			if ($urandom_range(0, 2) != 0) idle_input($urandom_range(1, 6));
		end
	endtask

	task automatic test_directed();
		logic [15:0] edge_ang[6] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h4000, 16'hC000};
		for (int s = 0; s < 4; s++) send_query(16'h2000, 16'h1000, 16'hF000, 2'(s));
		foreach (edge_ang[i]) send_query(edge_ang[i], edge_ang[i], edge_ang[i], 2'd2);
		set_arm(2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		for (int s = 0; s < 4; s++) send_query(16'h0000, 16'h0000, 16'h0000, 2'(s));
		send_query(16'h8000, 16'h0000, 16'h0000, 2'd3);
		send_query(16'h4000, 16'h0000, 16'h0000, 2'd3);
		set_arm(2'd0, 16'h0000, 16'h0000, 16'h0000);
		send_query(16'h1234, 16'h5678, 16'h9ABC, 2'd3);
		set_arm(2'd1, 16'h0001, 16'h8000, 16'h7FFF);
		send_query(16'h1234, 16'h5678, 16'h9ABC, 2'd3);
		send_query(16'hFFFF, 16'h0001, 16'h7FFF, 2'd1);
	endtask

	task automatic test_random_configs();
		for (int ph = 0; ph < 6; ph++) begin
			stall_mode = ph % 3;
			set_arm(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
					16'($urandom));
			random_burst(290);
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_configs();
		drain();
		if (errors == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end
endmodule
